>>> design/c8x_pkg.sv
package c8x_pkg;

    localparam int MEM_BYTES   = 4096;
    localparam int MEM_AW      = 12;
    localparam int STACK_DEPTH = 16;
    localparam int STACK_AW    = $clog2(STACK_DEPTH);
    localparam int STACK_CW    = $clog2(STACK_DEPTH + 1);
    localparam int FONT_BYTES  = 80;

    localparam logic [12:0] PC_START = 13'h200;
    localparam logic [12:0] PC_LIMIT = 13'd4095;

    typedef enum logic [2:0] {
        OP_EXEC  = 3'd0,
        OP_TICK  = 3'd1,
        OP_KEY   = 3'd2,
        OP_MWR   = 3'd3,
        OP_MRD   = 3'd4,
        OP_DRAWN = 3'd5,
        OP_START = 3'd6
    } oper_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_WKEY    = 3'd1,
        ST_WDRAW   = 3'd2,
        ST_BADOP   = 3'd3,
        ST_PCBOUND = 3'd4,
        ST_OVER    = 3'd5,
        ST_UNDER   = 3'd6,
        ST_HALTED  = 3'd7
    } status_t;

    typedef struct packed {
        logic [2:0]  operation;
        logic [7:0]  random_byte;
        logic [3:0]  key_index;
        logic        key_pressed;
        logic [11:0] address;
        logic [7:0]  write_data;
        logic        collision;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        clear_screen;
        logic        draw_request;
        logic [7:0]  draw_x;
        logic [7:0]  draw_y;
        logic [11:0] sprite_address;
        logic [3:0]  sprite_rows;
        logic        beep;
        logic [7:0]  read_data;
    } out_word_t;

    function automatic logic [7:0] font_byte(input logic [6:0] a);
        logic [7:0] r;
        begin
            case (a)
                7'd0: r = 8'hf0; 7'd1: r = 8'h90; 7'd2: r = 8'h90; 7'd3: r = 8'h90;
                7'd4: r = 8'hf0; 7'd5: r = 8'h20; 7'd6: r = 8'h60; 7'd7: r = 8'h20;
                7'd8: r = 8'h20; 7'd9: r = 8'h70; 7'd10: r = 8'hf0; 7'd11: r = 8'h10;
                7'd12: r = 8'hf0; 7'd13: r = 8'h80; 7'd14: r = 8'hf0; 7'd15: r = 8'hf0;
                7'd16: r = 8'h10; 7'd17: r = 8'hf0; 7'd18: r = 8'h10; 7'd19: r = 8'hf0;
                7'd20: r = 8'h90; 7'd21: r = 8'h90; 7'd22: r = 8'hf0; 7'd23: r = 8'h10;
                7'd24: r = 8'h10; 7'd25: r = 8'hf0; 7'd26: r = 8'h80; 7'd27: r = 8'hf0;
                7'd28: r = 8'h10; 7'd29: r = 8'hf0; 7'd30: r = 8'hf0; 7'd31: r = 8'h80;
                7'd32: r = 8'hf0; 7'd33: r = 8'h90; 7'd34: r = 8'hf0; 7'd35: r = 8'hf0;
                7'd36: r = 8'h10; 7'd37: r = 8'h20; 7'd38: r = 8'h40; 7'd39: r = 8'h40;
                7'd40: r = 8'hf0; 7'd41: r = 8'h90; 7'd42: r = 8'hf0; 7'd43: r = 8'h90;
                7'd44: r = 8'hf0; 7'd45: r = 8'hf0; 7'd46: r = 8'h90; 7'd47: r = 8'hf0;
                7'd48: r = 8'h10; 7'd49: r = 8'hf0; 7'd50: r = 8'hf0; 7'd51: r = 8'h90;
                7'd52: r = 8'hf0; 7'd53: r = 8'h90; 7'd54: r = 8'h90; 7'd55: r = 8'he0;
                7'd56: r = 8'h90; 7'd57: r = 8'he0; 7'd58: r = 8'h90; 7'd59: r = 8'he0;
                7'd60: r = 8'hf0; 7'd61: r = 8'h80; 7'd62: r = 8'h80; 7'd63: r = 8'h80;
                7'd64: r = 8'hf0; 7'd65: r = 8'he0; 7'd66: r = 8'h90; 7'd67: r = 8'h90;
                7'd68: r = 8'h90; 7'd69: r = 8'he0; 7'd70: r = 8'hf0; 7'd71: r = 8'h80;
                7'd72: r = 8'hf0; 7'd73: r = 8'h80; 7'd74: r = 8'hf0; 7'd75: r = 8'hf0;
                7'd76: r = 8'h80; 7'd77: r = 8'hf0; 7'd78: r = 8'h80; 7'd79: r = 8'h80;
                default: r = 8'h00;
            endcase
            return r;
        end
    endfunction

endpackage

>>> design/c8x_stream_if.sv
interface c8x_stream_if #(parameter type word_t = logic);
    logic  valid;
    logic  ready;
    word_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> design/c8x_ram.sv
module c8x_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> design/chip8_instruction_executor.sv
// CHIP-8 core. One word in (operation plus operands), one word out per word.
// Main memory (4096 bytes) and the return stack sit in single-port-write,
// registered-read RAMs; the sixteen V registers are flip-flops. Font bytes at
// 0..79 read from a constant table until that address is first written (one
// flag bit per font byte). An execute issues the high opcode read, collects
// both opcode bytes, decodes, and then forms the result; a return adds a
// stack read. FX55 stores up to 16 bytes, FX65 reads and then loads each of
// up to 16 bytes, and FX33 makes its three stores, all through the one
// memory port. Other operations form the result directly, a memory read
// after a separate read state. The result waits in an output register; the
// next word is taken once it has been delivered.
module chip8_instruction_executor (
    input  logic clk,
    input  logic rst_n,
    c8x_stream_if.sink   in_ch,
    c8x_stream_if.source out_ch
);
    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_FETCH_HI, S_FETCH_LO, S_DECODE, S_STK,
        S_BCD, S_STORE, S_LOAD, S_LOAD_W, S_MEMRD, S_OUT
    } state_t;

    state_t state_reg;
    c8x_pkg::in_word_t  in_reg;
    c8x_pkg::out_word_t out_reg;

    logic [7:0]  v_reg [16];
    logic [11:0] i_reg;
    logic [12:0] pc_reg;
    logic [c8x_pkg::STACK_CW-1:0] sp_reg;
    logic [7:0]  dt_reg, st_reg;
    logic        beep_reg;
    logic [15:0] keys_reg;
    logic        wkey_reg, wdraw_reg, run_reg;
    logic [3:0]  ktgt_reg;
    logic [c8x_pkg::FONT_BYTES-1:0] fontw_reg;
    logic [7:0]  ophi_reg, oplo_reg;
    logic [4:0]  cnt_reg;
    logic [11:0] maddr_reg;   // address of the pending memory read

    // memory port
    logic        m_we;
    logic [11:0] m_wa, m_ra;
    logic [7:0]  m_wd, m_rd;
    // stack port
    logic        s_we;
    logic [c8x_pkg::STACK_AW-1:0] s_wa, s_ra;
    logic [11:0] s_rd;

    c8x_ram #(.WIDTH(8), .DEPTH(c8x_pkg::MEM_BYTES)) u_mem (
        .clk(clk), .we(m_we), .waddr(m_wa), .wdata(m_wd), .raddr(m_ra), .rdata(m_rd)
    );
    c8x_ram #(.WIDTH(12), .DEPTH(c8x_pkg::STACK_DEPTH)) u_stk (
        .clk(clk), .we(s_we), .waddr(s_wa), .wdata(pc_reg[11:0]), .raddr(s_ra),
        .rdata(s_rd)
    );

    // font overlay: bytes never written read from the table
    logic [7:0] mbyte;
    always_comb
    begin
        mbyte = m_rd;
        if (maddr_reg < 12'(c8x_pkg::FONT_BYTES) && !fontw_reg[7'(maddr_reg)])
        begin
            mbyte = c8x_pkg::font_byte(7'(maddr_reg));
        end
    end

    logic [3:0]  ox, oy, on;
    logic [7:0]  onn, vx, vy;
    logic [7:0]  bcd_d;
    logic [1:0]  bcd_h;
    logic [6:0]  bcd_r;
    logic [14:0] bcd_m;
    logic [3:0]  bcd_t, bcd_o;
    assign ox  = ophi_reg[3:0];
    assign oy  = oplo_reg[7:4];
    assign on  = oplo_reg[3:0];
    assign onn = oplo_reg;
    assign vx  = v_reg[ox];
    assign vy  = v_reg[oy];

    // hundreds by compare and subtract; tens as (r * 205) >> 11, exact for r below 1029
    always_comb
    begin
        if (vx >= 8'd200)
        begin
            bcd_h = 2'd2;
            bcd_r = 7'(vx - 8'd200);
        end
        else if (vx >= 8'd100)
        begin
            bcd_h = 2'd1;
            bcd_r = 7'(vx - 8'd100);
        end
        else
        begin
            bcd_h = 2'd0;
            bcd_r = vx[6:0];
        end
        bcd_m = {8'd0, bcd_r} * 15'd205;
        bcd_t = bcd_m[14:11];
        bcd_o = 4'(bcd_r - {bcd_t, 3'b000} - {2'b00, bcd_t, 1'b0});
        case (cnt_reg[1:0])
            2'd0:    bcd_d = {6'd0, bcd_h};
            2'd1:    bcd_d = {4'd0, bcd_t};
            default: bcd_d = {4'd0, bcd_o};
        endcase
    end

    // write ports and read addresses of memory and stack
    always_comb
    begin
        m_we = 1'b0;
        m_wa = in_reg.address;
        m_wd = in_reg.write_data;
        m_ra = in_reg.address;
        s_we = 1'b0;
        s_wa = sp_reg[c8x_pkg::STACK_AW-1:0];
        s_ra = c8x_pkg::STACK_AW'(sp_reg - 1'b1);
        case (state_reg)
            S_RD:
            begin
                if (in_reg.operation == c8x_pkg::OP_MWR)
                begin
                    m_we = 1'b1;
                end
                if (in_reg.operation != c8x_pkg::OP_MRD)
                begin
                    m_ra = pc_reg[11:0];
                end
            end
            S_FETCH_HI: m_ra = 12'(pc_reg + 13'd1);
            S_BCD:
            begin
                m_we = 1'b1;
                m_wa = 12'(i_reg + 12'(cnt_reg));
                m_wd = bcd_d;
            end
            S_STORE:
            begin
                m_we = 1'b1;
                m_wa = 12'(i_reg + 12'(cnt_reg));
                m_wd = v_reg[cnt_reg[3:0]];
            end
            S_LOAD:   m_ra = 12'(i_reg + 12'(cnt_reg));
            S_DECODE:
            begin
                if (ophi_reg[7:4] == 4'h2 && sp_reg < c8x_pkg::STACK_CW'(c8x_pkg::STACK_DEPTH))
                begin
                    s_we = 1'b1;
                end
            end
            default: ;
        endcase
    end

    function automatic logic [2:0] stat(input logic r, input logic d, input logic k);
        begin
            if (!r) return c8x_pkg::ST_HALTED;
            if (d)  return c8x_pkg::ST_WDRAW;
            if (k)  return c8x_pkg::ST_WKEY;
            return c8x_pkg::ST_OK;
        end
    endfunction

    assign in_ch.ready  = (state_reg == S_IDLE) && !out_ch.valid;
    logic out_v_reg;
    assign out_ch.valid = out_v_reg;
    assign out_ch.data  = out_reg;

    logic [3:0] lowkey;
    logic       anykey;
    always_comb
    begin
        lowkey = 4'd0;
        anykey = 1'b0;
        for (int k = 15; k >= 0; k--)
        begin
            if (keys_reg[k])
            begin
                lowkey = 4'(k);
                anykey = 1'b1;
            end
        end
    end

    logic [8:0]  add9;
    logic [12:0] sum13;
    assign add9  = {1'b0, vx} + {1'b0, vy};
    assign sum13 = {1'b0, i_reg} + {5'd0, vx};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_v_reg <= 1'b0;
            for (int k = 0; k < 16; k++)
            begin
                v_reg[k] <= 8'd0;
            end
            i_reg     <= 12'd0;
            pc_reg    <= c8x_pkg::PC_START;
            sp_reg    <= '0;
            dt_reg    <= 8'd0;
            st_reg    <= 8'd0;
            beep_reg  <= 1'b0;
            keys_reg  <= 16'd0;
            wkey_reg  <= 1'b0;
            wdraw_reg <= 1'b0;
            run_reg   <= 1'b0;
            ktgt_reg  <= 4'd0;
            fontw_reg <= '0;
            cnt_reg   <= 5'd0;
        end
        else
        begin
            if (out_v_reg && out_ch.ready)
            begin
                out_v_reg <= 1'b0;
            end
            if (m_we && m_wa < 12'(c8x_pkg::FONT_BYTES))
            begin
                fontw_reg[7'(m_wa)] <= 1'b1;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_ch.valid && in_ch.ready)
                    begin
                        in_reg    <= in_ch.data;
                        out_reg   <= '0;
                        state_reg <= S_RD;
                    end
                end
                S_RD:
                begin
                    maddr_reg <= in_reg.address;
                    state_reg <= S_OUT;
                    case (in_reg.operation)
                        c8x_pkg::OP_EXEC:
                        begin
                            if (run_reg && !wdraw_reg)
                            begin
                                if (wkey_reg)
                                begin
                                    if (anykey)
                                    begin
                                        v_reg[ktgt_reg] <= {4'd0, lowkey};
                                        wkey_reg <= 1'b0;
                                    end
                                end
                                else if (pc_reg >= c8x_pkg::PC_LIMIT)
                                begin
                                    run_reg <= 1'b0;
                                    out_reg.status <= c8x_pkg::ST_PCBOUND;
                                    state_reg <= S_OUT;
                                end
                                else
                                begin
                                    maddr_reg <= pc_reg[11:0];
                                    state_reg <= S_FETCH_HI;
                                end
                            end
                        end
                        c8x_pkg::OP_TICK:
                        begin
                            if (run_reg)
                            begin
                                if (dt_reg != 8'd0) dt_reg <= dt_reg - 8'd1;
                                if (st_reg != 8'd0)
                                begin
                                    st_reg   <= st_reg - 8'd1;
                                    beep_reg <= (st_reg > 8'd1);
                                end
                            end
                        end
                        c8x_pkg::OP_KEY:   keys_reg[in_reg.key_index] <= in_reg.key_pressed;
                        c8x_pkg::OP_MRD:   state_reg <= S_MEMRD;
                        c8x_pkg::OP_DRAWN:
                        begin
                            if (wdraw_reg)
                            begin
                                v_reg[15] <= {7'd0, in_reg.collision};
                                wdraw_reg <= 1'b0;
                            end
                        end
                        c8x_pkg::OP_START: run_reg <= 1'b1;
                        default: ;
                    endcase
                end
                S_MEMRD:
                begin
                    out_reg.read_data <= mbyte;
                    state_reg <= S_OUT;
                end
                S_FETCH_HI:
                begin
                    ophi_reg  <= mbyte;
                    maddr_reg <= 12'(pc_reg + 13'd1);
                    state_reg <= S_FETCH_LO;
                end
                S_FETCH_LO:
                begin
                    oplo_reg  <= mbyte;
                    pc_reg    <= pc_reg + 13'd2;
                    state_reg <= S_DECODE;
                end
                S_DECODE:
                begin
                    state_reg <= S_OUT;
                    cnt_reg   <= 5'd0;
                    case (ophi_reg[7:4])
                        4'h0:
                        begin
                            if (ox == 4'd0)
                            begin
                                if (onn == 8'he0) out_reg.clear_screen <= 1'b1;
                                else if (onn == 8'hee)
                                begin
                                    if (sp_reg == '0)
                                    begin
                                        run_reg <= 1'b0;
                                        out_reg.status <= c8x_pkg::ST_UNDER;
                                    end
                                    else
                                    begin
                                        sp_reg <= sp_reg - 1'b1;
                                        state_reg <= S_STK;
                                    end
                                end
                                else
                                begin
                                    run_reg <= 1'b0;
                                    out_reg.status <= c8x_pkg::ST_BADOP;
                                end
                            end
                        end
                        4'h1: pc_reg <= {1'b0, ox, onn};
                        4'h2:
                        begin
                            if (sp_reg >= c8x_pkg::STACK_CW'(c8x_pkg::STACK_DEPTH))
                            begin
                                run_reg <= 1'b0;
                                out_reg.status <= c8x_pkg::ST_OVER;
                            end
                            else
                            begin
                                sp_reg <= sp_reg + 1'b1;
                                pc_reg <= {1'b0, ox, onn};
                            end
                        end
                        4'h3: if (vx == onn) pc_reg <= pc_reg + 13'd2;
                        4'h4: if (vx != onn) pc_reg <= pc_reg + 13'd2;
                        4'h5:
                        begin
                            if (on != 4'd0)
                            begin
                                run_reg <= 1'b0;
                                out_reg.status <= c8x_pkg::ST_BADOP;
                            end
                            else if (vx == vy) pc_reg <= pc_reg + 13'd2;
                        end
                        4'h6: v_reg[ox] <= onn;
                        4'h7: v_reg[ox] <= vx + onn;
                        4'h8:
                        begin
                            case (on)
                                4'h0: v_reg[ox] <= vy;
                                4'h1: v_reg[ox] <= vx | vy;
                                4'h2: v_reg[ox] <= vx & vy;
                                4'h3: v_reg[ox] <= vx ^ vy;
                                4'h4:
                                begin
                                    v_reg[ox] <= add9[7:0];
                                    v_reg[15] <= {7'd0, add9[8]};
                                end
                                4'h5:
                                begin
                                    v_reg[ox] <= vx - vy;
                                    v_reg[15] <= {7'd0, vx >= vy};
                                end
                                4'h6:
                                begin
                                    v_reg[ox] <= {1'b0, vx[7:1]};
                                    v_reg[15] <= {7'd0, vx[0]};
                                end
                                4'h7:
                                begin
                                    v_reg[ox] <= vy - vx;
                                    v_reg[15] <= {7'd0, vy >= vx};
                                end
                                4'he:
                                begin
                                    v_reg[ox] <= {vx[6:0], 1'b0};
                                    v_reg[15] <= {7'd0, vx[7]};
                                end
                                default:
                                begin
                                    run_reg <= 1'b0;
                                    out_reg.status <= c8x_pkg::ST_BADOP;
                                end
                            endcase
                        end
                        4'h9: if (vx != vy) pc_reg <= pc_reg + 13'd2;
                        4'ha: i_reg <= {ox, onn};
                        4'hb: pc_reg <= {1'b0, ox, onn} + {5'd0, v_reg[0]};
                        4'hc: v_reg[ox] <= in_reg.random_byte & onn;
                        4'hd:
                        begin
                            out_reg.draw_request   <= 1'b1;
                            out_reg.draw_x         <= vx;
                            out_reg.draw_y         <= vy;
                            out_reg.sprite_address <= i_reg;
                            out_reg.sprite_rows    <= on;
                            wdraw_reg <= 1'b1;
                        end
                        4'he:
                        begin
                            if (onn == 8'h9e)
                            begin
                                if (keys_reg[vx[3:0]]) pc_reg <= pc_reg + 13'd2;
                            end
                            else if (onn == 8'ha1)
                            begin
                                if (!keys_reg[vx[3:0]]) pc_reg <= pc_reg + 13'd2;
                            end
                            else
                            begin
                                run_reg <= 1'b0;
                                out_reg.status <= c8x_pkg::ST_BADOP;
                            end
                        end
                        default:
                        begin
                            case (onn)
                                8'h07: v_reg[ox] <= dt_reg;
                                8'h0a:
                                begin
                                    ktgt_reg <= ox;
                                    wkey_reg <= 1'b1;
                                end
                                8'h15: dt_reg <= vx;
                                8'h18: st_reg <= vx;
                                8'h1e:
                                begin
                                    v_reg[15] <= {7'd0, sum13[12]};
                                    i_reg <= sum13[11:0];
                                end
                                8'h29: i_reg <= 12'({4'd0, vx} * 12'd5);
                                8'h33: state_reg <= S_BCD;
                                8'h55: state_reg <= S_STORE;
                                8'h65: state_reg <= S_LOAD;
                                default:
                                begin
                                    run_reg <= 1'b0;
                                    out_reg.status <= c8x_pkg::ST_BADOP;
                                end
                            endcase
                        end
                    endcase
                end
                S_STK:
                begin
                    // stack read data valid this cycle
                    pc_reg    <= {1'b0, s_rd};
                    state_reg <= S_OUT;
                end
                S_BCD:
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd2) state_reg <= S_OUT;
                end
                S_STORE:
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg[3:0] == ox)
                    begin
                        i_reg <= 12'(i_reg + {8'd0, ox} + 12'd1);
                        state_reg <= S_OUT;
                    end
                end
                S_LOAD:
                begin
                    maddr_reg <= 12'(i_reg + 12'(cnt_reg));
                    state_reg <= S_LOAD_W;
                end
                S_LOAD_W:
                begin
                    v_reg[cnt_reg[3:0]] <= mbyte;
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg[3:0] == ox)
                    begin
                        i_reg <= 12'(i_reg + {8'd0, ox} + 12'd1);
                        state_reg <= S_OUT;
                    end
                    else state_reg <= S_LOAD;
                end
                S_OUT:
                begin
                    if (out_reg.status == c8x_pkg::ST_OK)
                    begin
                        out_reg.status <= stat(run_reg, wdraw_reg, wkey_reg);
                    end
                    out_reg.beep <= beep_reg;
                    out_v_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= c8x_pkg::STACK_CW'(c8x_pkg::STACK_DEPTH))
        else $error("stack count beyond depth");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ch.ready)
        else $error("ready while busy");
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> !out_v_reg)
        else $error("result before work");
    a_draw_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && out_reg.draw_request) |-> wdraw_reg)
        else $error("draw request without wait");
endmodule
